FILE: rtl/core/b32d_pkg.sv
// types, character codes and symbol lookup for the base32 decoder
`default_nettype none

package b32d_pkg;

	localparam logic [7:0] CHAR_A     = 8'h41;
	localparam logic [7:0] CHAR_Z     = 8'h5A;
	localparam logic [7:0] CHAR_TWO   = 8'h32;
	localparam logic [7:0] CHAR_SEVEN = 8'h37;
	localparam logic [7:0] CHAR_PAD   = 8'h3D;
	localparam logic [4:0] DIGIT_BASE = 5'd26;

	typedef struct packed {
		logic       ok;
		logic [4:0] val;
	} sym_t;

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       bad;
		logic       last;
	} res_t;

	function automatic sym_t sym_decode(input logic [7:0] c);
		sym_t       s;
		logic [7:0] d_alpha;
		logic [7:0] d_digit;
		d_alpha = c - CHAR_A;
		d_digit = c - CHAR_TWO;
		s.ok    = 1'b0;
		s.val   = 5'd0;
		if (c >= CHAR_A && c <= CHAR_Z) begin
			s.ok  = 1'b1;
			s.val = d_alpha[4:0];
		end else if (c >= CHAR_TWO && c <= CHAR_SEVEN) begin
			s.ok  = 1'b1;
			s.val = d_digit[4:0] + DIGIT_BASE;
		end
		return s;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/base32_decoder.sv
// base32 decoder top level: input register, decode step and result queue
`default_nettype none

// Streaming base32 decoder, upper-case alphabet A-Z and 2-7. One character is
// taken per item; each symbol adds 5 bits and a byte leaves whenever 8 bits
// are complete. '=' ends decoding for the rest of the string, any other
// character outside the alphabet marks the string bad. The item flagged with
// end_of_string produces the final result (last_result 1, bad_input valid),
// possibly preceded by one more data byte, and clears the decoder state.
// Rate: one item per cycle. An accepted item sits in the input register while
// it is decoded; its results (zero, one or two) enter a QUEUE_DEPTH entry
// result queue and appear on the output from the next cycle on. The input
// register holds its item while fewer than two queue entries are free, so
// the sink's throughput of one result per cycle sets the pace: items that
// yield two results slow the input down.
module base32_decoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire        clk,
	input  wire        arst_n,

	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [7:0] in_char,
	input  wire        end_of_string,

	output logic       out_valid,
	input  wire        out_stall,
	output logic [7:0] out_byte,
	output logic       has_data,
	output logic       bad_input,
	output logic       last_result
);

	localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eos_s1;

	// decoder state
	logic [7:0] acc_q;
	logic [2:0] pend_q;
	logic       stop_q;
	logic       err_q;

	// result queue
	b32d_pkg::res_t   queue_q [QUEUE_DEPTH];
	logic [QW-1:0]    wr_q;
	logic [QW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;

	logic             adv;
	b32d_pkg::sym_t   sym;
	logic             active;
	logic             is_pad;
	logic             take_sym;
	logic             set_err;
	logic             err_n;
	logic [3:0]       sum;
	logic [3:0]       rem;
	logic [12:0]      comb;
	logic [12:0]      comb_sh;
	logic             emit;
	logic [7:0]       main_byte;
	logic [7:0]       acc_n;
	logic [2:0]       pend_n;
	logic             flush;
	logic [3:0]       flush_sh;
	logic [7:0]       flush_byte;
	b32d_pkg::res_t   r0;
	b32d_pkg::res_t   r1;
	logic             push0;
	logic             push1;
	logic             pop;
	logic [QW-1:0]    wr1;
	logic [QW-1:0]    wr2;
	logic [QW-1:0]    rd_n;
	logic [CW-1:0]    cnt_add;

	function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
		return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + QW'(1);
	endfunction

	assign adv      = valid_s1 && (cnt_q <= CW'(QUEUE_DEPTH - 2));
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= in_char;
			eos_s1  <= end_of_string;
		end
	end

	// decode step
	always_comb begin
		sym      = b32d_pkg::sym_decode(char_s1);
		active   = !stop_q && !err_q;
		is_pad   = (char_s1 == b32d_pkg::CHAR_PAD);
		take_sym = active && sym.ok;
		set_err  = active && !is_pad && !sym.ok;
		err_n    = err_q || set_err;
		sum      = {1'b0, pend_q} + 4'd5;
		rem      = sum - 4'd8;
		comb     = {acc_q, sym.val};
		comb_sh  = comb >> rem;
		emit     = take_sym && sum[3];
		main_byte = comb_sh[7:0];
		if (!take_sym) begin
			acc_n  = acc_q;
			pend_n = pend_q;
		end else if (sum[3]) begin
			acc_n  = comb[7:0] & ~(8'hFF << rem);
			pend_n = rem[2:0];
		end else begin
			acc_n  = comb[7:0];
			pend_n = sum[2:0];
		end
		flush      = eos_s1 && !err_n && pend_n[2];
		flush_sh   = 4'd11 - {1'b0, pend_n};
		flush_byte = acc_n << flush_sh;

		if (emit) begin
			r0.data = main_byte;
			r0.has  = 1'b1;
			r0.last = eos_s1 && !flush;
			r0.bad  = eos_s1 && !flush && err_n;
		end else if (flush) begin
			r0.data = flush_byte;
			r0.has  = 1'b1;
			r0.last = 1'b1;
			r0.bad  = err_n;
		end else begin
			r0.data = 8'd0;
			r0.has  = 1'b0;
			r0.last = 1'b1;
			r0.bad  = err_n;
		end
		r1.data = flush_byte;
		r1.has  = 1'b1;
		r1.last = 1'b1;
		r1.bad  = err_n;

		push0 = adv && (emit || eos_s1);
		push1 = adv && emit && flush;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= 8'd0;
			pend_q <= 3'd0;
			stop_q <= 1'b0;
			err_q  <= 1'b0;
		end else if (adv) begin
			if (eos_s1) begin
				acc_q  <= 8'd0;
				pend_q <= 3'd0;
				stop_q <= 1'b0;
				err_q  <= 1'b0;
			end else begin
				acc_q  <= acc_n;
				pend_q <= pend_n;
				stop_q <= stop_q || (active && is_pad);
				err_q  <= err_n;
			end
		end
	end

	// result queue
	assign pop     = out_valid && !out_stall;
	assign wr1     = ptr_inc(wr_q);
	assign wr2     = ptr_inc(wr1);
	assign rd_n    = ptr_inc(rd_q);
	assign cnt_add = CW'(push0) + CW'(push1);

	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (push0 && wr_q == QW'(i)) begin
				queue_q[i] <= r0;
			end else if (push1 && wr1 == QW'(i)) begin
				queue_q[i] <= r1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push1) begin
				wr_q <= wr2;
			end else if (push0) begin
				wr_q <= wr1;
			end
			if (pop) begin
				rd_q <= rd_n;
			end
			cnt_q <= cnt_q + cnt_add - CW'(pop);
		end
	end

	assign out_valid   = (cnt_q != '0);
	assign out_byte    = queue_q[rd_q].data;
	assign has_data    = queue_q[rd_q].has;
	assign bad_input   = queue_q[rd_q].bad;
	assign last_result = queue_q[rd_q].last;

`ifndef ASSERT_OFF
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QUEUE_DEPTH))
		else $error("result queue count out of range");

	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eos_s1 |=> pend_q == 3'd0 && !stop_q && !err_q && acc_q == 8'd0)
		else $error("decoder state not cleared after end of string");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_data |-> last_result && out_byte == 8'd0)
		else $error("empty result that is not the final one");

	a_flush_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		push1 |-> !err_n && eos_s1)
		else $error("second byte pushed outside a clean string end");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_base32_decoder.sv
// self-checking testbench for base32_decoder: directed and random strings under four idle patterns
`default_nettype none

module tb_base32_decoder;

	localparam int WATCHDOG_LIMIT = 2000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_char;
	logic       end_of_string;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic       has_data;
	logic       bad_input;
	logic       last_result;

	// decoder state as the testbench sees it
	logic [7:0] pend_bits;
	logic [3:0] free_bits;
	logic       pad_seen;
	logic       bad_seen;

	b32d_pkg::res_t decoded_fifo[$];

	int send_idle_pct;
	int recv_stall_pct;
	int fail_count = 0;
	int items_sent;
	int strings_sent;
	int results_checked = 0;
	int quiet_cycles = 0;

	base32_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_char       (in_char),
		.end_of_string (end_of_string),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.has_data      (has_data),
		.bad_input     (bad_input),
		.last_result   (last_result)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// {ok, value}
	function automatic logic [5:0] symbol_of(input logic [7:0] c);
		logic [7:0] off;
		if (c >= b32d_pkg::CHAR_A && c <= b32d_pkg::CHAR_Z) begin
			off = c - b32d_pkg::CHAR_A;
			return {1'b1, off[4:0]};
		end
		if (c >= b32d_pkg::CHAR_TWO && c <= b32d_pkg::CHAR_SEVEN) begin
			off = c - b32d_pkg::CHAR_TWO + 8'd26;
			return {1'b1, off[4:0]};
		end
		return 6'd0;
	endfunction

	function automatic logic [7:0] random_symbol();
		int v;
		v = $urandom_range(31);
		if (v < 26)
			return b32d_pkg::CHAR_A + 8'(v);
		return b32d_pkg::CHAR_TWO + 8'(v - 26);
	endfunction

	function automatic logic [7:0] random_noise();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(255));
		end while (symbol_of(c) != 6'd0 || c == b32d_pkg::CHAR_PAD);
		return c;
	endfunction

	task automatic clear_decode_state();
		pend_bits = 8'd0;
		free_bits = 4'd8;
		pad_seen  = 1'b0;
		bad_seen  = 1'b0;
	endtask

	// work out the results of one accepted item and queue them
	task automatic decode_char(input logic [7:0] c, input logic eos);
		logic [5:0]     sym;
		logic [7:0]     made [0:1];
		int             n;
		b32d_pkg::res_t r;
		n = 0;
		items_sent++;
		if (!pad_seen && !bad_seen) begin
			if (c == b32d_pkg::CHAR_PAD) begin
				pad_seen = 1'b1;
			end else begin
				sym = symbol_of(c);
				if (!sym[5]) begin
					bad_seen = 1'b1;
				end else begin
					for (int i = 4; i >= 0; i--) begin
						pend_bits = {pend_bits[6:0], sym[i]};
						free_bits = free_bits - 4'd1;
						if (free_bits == 4'd0) begin
							made[n] = pend_bits;
							n++;
							pend_bits = 8'd0;
							free_bits = 4'd8;
						end
					end
				end
			end
		end
		// tail flush of 4 to 7 pending bits
		if (eos && !bad_seen && free_bits >= 4'd1 && free_bits <= 4'd4) begin
			made[n] = pend_bits << (free_bits + 4'd3);
			n++;
		end
		if (eos && n == 0) begin
			r.data = 8'd0;
			r.has  = 1'b0;
			r.bad  = bad_seen;
			r.last = 1'b1;
			decoded_fifo.insert(decoded_fifo.size(), r);
		end else begin
			for (int k = 0; k < n; k++) begin
				r.data = made[k];
				r.has  = 1'b1;
				r.bad  = (eos && k == n - 1) ? bad_seen : 1'b0;
				r.last = (eos && k == n - 1);
				decoded_fifo.insert(decoded_fifo.size(), r);
			end
		end
		if (eos) begin
			strings_sent++;
			clear_decode_state();
		end
	endtask

	task automatic send_char(input logic [7:0] c, input logic eos);
		logic taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		in_char       <= c;
		end_of_string <= eos;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		decode_char(c, eos);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	task automatic send_random_string();
		logic [7:0] chars[$];
		int         kind;
		int         len;
		int         pos;
		kind = $urandom_range(99);
		len  = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		for (int i = 0; i < len; i++)
			chars.insert(chars.size(), random_symbol());
		if (kind < 70) begin
			if ($urandom_range(1))
				repeat ($urandom_range(1, 6)) chars.insert(chars.size(), b32d_pkg::CHAR_PAD);
		end else if (kind < 85) begin
			pos = $urandom_range(len - 1);
			chars[pos] = random_noise();
		end else if (kind < 95) begin
			chars.insert(chars.size(), b32d_pkg::CHAR_PAD);
			repeat ($urandom_range(1, 4))
				chars.insert(chars.size(), 8'($urandom_range(255)));
		end else begin
			foreach (chars[i])
				chars[i] = 8'($urandom_range(255));
		end
		foreach (chars[i])
			send_char(chars[i], i == chars.size() - 1);
	endtask

	task automatic run_random(input int target);
		int stop_at;
		stop_at = items_sent + target;
		while (items_sent < stop_at)
			send_random_string();
	endtask

	task automatic test_directed();
		send_text("AZ27");
		send_text("MZXW6===");
		send_text("A");
		send_text("AB");
		send_text("=");
		send_char(8'hFF, 1'b0);
		send_char(b32d_pkg::CHAR_A, 1'b0);
		send_char(b32d_pkg::CHAR_PAD, 1'b1);
		send_char(b32d_pkg::CHAR_A, 1'b0);
		send_char(b32d_pkg::CHAR_PAD, 1'b0);
		send_char(8'h00, 1'b1);
		send_char(b32d_pkg::CHAR_A - 8'd1, 1'b1);
		send_char(b32d_pkg::CHAR_Z + 8'd1, 1'b1);
		send_char(b32d_pkg::CHAR_TWO - 8'd1, 1'b1);
		send_char(b32d_pkg::CHAR_SEVEN + 8'd1, 1'b1);
	endtask

	task automatic test_no_idling();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_random(90);
	endtask

	task automatic test_sender_gaps();
		send_idle_pct  = 52;
		recv_stall_pct = 0;
		run_random(90);
	endtask

	task automatic test_receiver_stalls();
		send_idle_pct  = 0;
		recv_stall_pct = 52;
		run_random(90);
	endtask

	task automatic test_both_idle();
		send_idle_pct  = 33;
		recv_stall_pct = 33;
		run_random(90);
	endtask

	// result checker, sampled mid-cycle where all signals are settled
	always @(negedge clk) begin
		b32d_pkg::res_t got;
		b32d_pkg::res_t want;
		if (arst_n && out_valid && !out_stall) begin
			got.data = out_byte;
			got.has  = has_data;
			got.bad  = bad_input;
			got.last = last_result;
			if (decoded_fifo.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: byte %02h has_data %b bad_input %b last %b",
						got.data, got.has, got.bad, got.last);
			end else begin
				want = decoded_fifo.pop_front();
				results_checked++;
				if (got !== want) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("mismatch: expected byte %02h has_data %b bad_input %b last %b",
							want.data, want.has, want.bad, want.last);
						$display("          got      byte %02h has_data %b bad_input %b last %b",
							got.data, got.has, got.bad, got.last);
					end
				end
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(negedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_char        = 8'd0;
		end_of_string  = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		items_sent     = 0;
		strings_sent   = 0;
		clear_decode_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_no_idling();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();

		in_valid       <= 1'b0;
		recv_stall_pct = 0;
		while (decoded_fifo.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("covered %0d strings with %0d characters, %0d results checked",
			strings_sent, items_sent, results_checked);
		$display("idle patterns: none, sender gaps, receiver stalls, both sides");
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d failures", fail_count);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: base32_decoder.f
rtl/core/b32d_pkg.sv
rtl/core/base32_decoder.sv
tb/tb_base32_decoder.sv
